[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the dispatcher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define RRD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");

// cond must never be seen outside reset
`define RRD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define RRD_ASSERT(lbl, clk, rstn, prop)
`define RRD_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

[rtl/rrd_pkg.sv]
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared constants and types of the round-robin dispatcher.
// ----------------------------------------------------------------------------
package rrd_pkg;

  localparam int MAX_PROCS = 16;
  localparam int TIME_BITS = 12;
  localparam int PROC_W    = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int CLK_W     = 20;
  localparam int QUANT_W   = 12;
  localparam int PCNT_W    = 5;
  localparam int CFG_W     = 12;
  localparam int SLOT_W    = 4;
  localparam int IN_DW     = 32;
  localparam int OUT_DW    = 112;

  typedef enum logic {
    CFG_QUANTUM = 1'b0,
    CFG_PCOUNT  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_DISPATCH = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_IDLE     = 2'd0,
    KIND_RUN      = 2'd1,
    KIND_ALL_DONE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_POP,
    ST_CALC,
    ST_TAT,
    ST_FIN
  } state_e;

endpackage

[rtl/rrd_ram.sv]
// ----------------------------------------------------------------------------
// rrd_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/round_robin_dispatcher.sv]
// Load beat: writes the slot table and clears the schedule; no result beat.
// Dispatch beat: a run slice goes through decide, pop, calc and turnaround, then an
// arrival scan; an idle tick bumps time, then scans; an all-done reply goes straight
// to the output. The first dispatch after a load adds a seeding scan. Each arrival
// scan reads the slot table one slot a cycle. A new beat is taken once the result
// is in the output register. Reset clears the schedule, sets quantum and count to 1.
// ----------------------------------------------------------------------------
// round_robin_dispatcher
// Round-robin time-slice dispatcher over a table of processes kept in RAM.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module round_robin_dispatcher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic                        cfg_addr_i,
  input  logic [rrd_pkg::CFG_W-1:0]   cfg_wdata_i,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [rrd_pkg::IN_DW-1:0]   s_axis_tdata,  // slot, arrival_time, burst_time
  input  logic                        s_axis_tuser,  // opcode
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // run_slot, slice_start, slice_end, process_done, completion_time,
  // turnaround_time, waiting_time, all_complete
  output logic [rrd_pkg::OUT_DW-1:0]  m_axis_tdata,
  output logic [1:0]                  m_axis_tuser   // slice_kind
);

  import rrd_pkg::*;

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  state_e                 state_q, state_d;
  logic [QUANT_W-1:0]     tq_q;
  logic [PCNT_W-1:0]      pc_q;
  logic [MAX_PROCS-1:0]   started_q, started_d;   // remaining entry written since load
  logic [MAX_PROCS-1:0]   queued_q, queued_d;
  logic [PROC_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CLK_W-1:0]       time_q, time_d;
  logic [CNT_W-1:0]       fin_q, fin_d;
  logic                   seeded_q, seeded_d;
  logic                   chk_vld_q, chk_vld_d;
  logic                   out_valid_q, out_valid_d;

  logic                   seed_q, seed_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [PROC_W-1:0]      chk_idx_q, chk_idx_d;
  logic [PROC_W-1:0]      s_q, s_d;
  kind_e                  kind_q, kind_d;
  logic [CLK_W-1:0]       start_q, start_d;
  logic                   done_q, done_d;
  logic [TIME_BITS-1:0]   arr_q, arr_d;
  logic [TIME_BITS-1:0]   burst_q, burst_d;
  logic [CLK_W-1:0]       tat_q, tat_d;

  kind_e                  o_kind_q, o_kind_d;
  logic [SLOT_W-1:0]      o_slot_q, o_slot_d;
  logic [CLK_W-1:0]       o_start_q, o_start_d;
  logic [CLK_W-1:0]       o_end_q, o_end_d;
  logic                   o_done_q, o_done_d;
  logic [CLK_W-1:0]       o_comp_q, o_comp_d;
  logic [CLK_W-1:0]       o_tat_q, o_tat_d;
  logic [CLK_W-1:0]       o_wait_q, o_wait_d;
  logic                   o_all_q, o_all_d;

  // --------------------------------------------------------------------------
  // memories
  // --------------------------------------------------------------------------
  logic                     proc_we;
  logic [PROC_W-1:0]        proc_waddr, proc_raddr;
  logic [2*TIME_BITS-1:0]   proc_wdata, proc_rd;
  logic                     rem_we;
  logic [PROC_W-1:0]        rem_raddr;
  logic [TIME_BITS-1:0]     rem_wdata, rem_rd;
  logic                     ring_we;
  logic [PROC_W-1:0]        ring_waddr;
  logic [PROC_W-1:0]        ring_wdata, ring_rd;

  // arrival in the low half, burst in the high half
  rrd_ram #(.WIDTH(2*TIME_BITS), .DEPTH(MAX_PROCS)) u_proc_ram (
    .clk_i   (clk_i),
    .we_i    (proc_we),
    .waddr_i (proc_waddr),
    .wdata_i (proc_wdata),
    .raddr_i (proc_raddr),
    .rdata_o (proc_rd)
  );

  rrd_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_PROCS)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (s_q),
    .wdata_i (rem_wdata),
    .raddr_i (rem_raddr),
    .rdata_o (rem_rd)
  );

  rrd_ram #(.WIDTH(PROC_W), .DEPTH(MAX_PROCS)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (head_q),
    .rdata_o (ring_rd)
  );

  // --------------------------------------------------------------------------
  // input decode and derived values
  // --------------------------------------------------------------------------
  logic                   in_acc;
  opcode_e                in_op;
  logic [SLOT_W-1:0]      in_slot;
  logic [TIME_BITS-1:0]   in_arr, in_bt, bt_fix;
  logic [CNT_W-1:0]       n_use;
  logic [QUANT_W-1:0]     quantum;
  logic [CNT_W-1:0]       tail_sum;
  logic [PROC_W-1:0]      tail;
  logic [PROC_W-1:0]      head_inc;
  logic [TIME_BITS-1:0]   arr_rd, burst_rd, rem_cur, run_len;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_op         = opcode_e'(s_axis_tuser);
  assign in_slot       = s_axis_tdata[SLOT_W-1:0];
  assign in_arr        = s_axis_tdata[SLOT_W +: TIME_BITS];
  assign in_bt         = s_axis_tdata[SLOT_W+TIME_BITS +: TIME_BITS];
  assign bt_fix        = (in_bt == '0) ? TIME_BITS'(1) : in_bt;

  always_comb begin
    if (pc_q == '0) begin
      n_use = CNT_W'(1);
    end else if (pc_q > PCNT_W'(MAX_PROCS)) begin
      n_use = CNT_W'(MAX_PROCS);
    end else begin
      n_use = CNT_W'(pc_q);
    end
  end

  assign quantum  = (tq_q == '0) ? QUANT_W'(1) : tq_q;
  assign tail_sum = CNT_W'(head_q) + count_q;
  assign tail     = (tail_sum >= CNT_W'(MAX_PROCS)) ?
                    PROC_W'(tail_sum - CNT_W'(MAX_PROCS)) : PROC_W'(tail_sum);
  assign head_inc = (head_q == PROC_W'(MAX_PROCS - 1)) ? '0 : head_q + PROC_W'(1);

  assign arr_rd   = proc_rd[TIME_BITS-1:0];
  assign burst_rd = proc_rd[2*TIME_BITS-1:TIME_BITS];
  assign rem_cur  = started_q[s_q] ? rem_rd : burst_rd;
  assign run_len  = (rem_cur < TIME_BITS'(quantum)) ? rem_cur : TIME_BITS'(quantum);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    started_d   = started_q;
    queued_d    = queued_q;
    head_d      = head_q;
    count_d     = count_q;
    time_d      = time_q;
    fin_d       = fin_q;
    seeded_d    = seeded_q;
    chk_vld_d   = chk_vld_q;
    out_valid_d = out_valid_q;
    seed_d      = seed_q;
    cnt_d       = cnt_q;
    chk_idx_d   = chk_idx_q;
    s_d         = s_q;
    kind_d      = kind_q;
    start_d     = start_q;
    done_d      = done_q;
    arr_d       = arr_q;
    burst_d     = burst_q;
    tat_d       = tat_q;
    o_kind_d    = o_kind_q;
    o_slot_d    = o_slot_q;
    o_start_d   = o_start_q;
    o_end_d     = o_end_q;
    o_done_d    = o_done_q;
    o_comp_d    = o_comp_q;
    o_tat_d     = o_tat_q;
    o_wait_d    = o_wait_q;
    o_all_d     = o_all_q;

    proc_we    = 1'b0;
    proc_waddr = in_slot[PROC_W-1:0];
    proc_wdata = {bt_fix, in_arr};
    proc_raddr = cnt_q[PROC_W-1:0];
    rem_we     = 1'b0;
    rem_raddr  = ring_rd;
    rem_wdata  = rem_cur - run_len;
    ring_we    = 1'b0;
    ring_waddr = tail;
    ring_wdata = chk_idx_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_LOAD) begin
            proc_we   = 1'b1;
            started_d = '0;
            queued_d  = '0;
            head_d    = '0;
            count_d   = '0;
            time_d    = '0;
            fin_d     = '0;
            seeded_d  = 1'b0;
          end else begin
            start_d = time_q;
            kind_d  = KIND_IDLE;
            done_d  = 1'b0;
            if (fin_q >= n_use) begin
              kind_d  = KIND_ALL_DONE;
              state_d = ST_FIN;
            end else if (!seeded_q) begin
              seeded_d  = 1'b1;
              seed_d    = 1'b1;
              cnt_d     = '0;
              chk_vld_d = 1'b0;
              state_d   = ST_SCAN;
            end else begin
              state_d = ST_DECIDE;
            end
          end
        end
      end

      // one slot read per cycle, compared in the following cycle
      ST_SCAN: begin
        if (chk_vld_q && (CLK_W'(arr_rd) <= time_q) && !queued_q[chk_idx_q] &&
            (count_q < CNT_W'(MAX_PROCS))) begin
          ring_we             = 1'b1;
          ring_wdata          = chk_idx_q;
          count_d             = count_q + CNT_W'(1);
          queued_d[chk_idx_q] = 1'b1;
        end
        if (cnt_q < n_use) begin
          proc_raddr = cnt_q[PROC_W-1:0];
          chk_vld_d  = 1'b1;
          chk_idx_d  = cnt_q[PROC_W-1:0];
          cnt_d      = cnt_q + CNT_W'(1);
        end else begin
          chk_vld_d = 1'b0;
          if (!chk_vld_q) begin
            state_d = seed_q ? ST_DECIDE : ST_FIN;
          end
        end
      end

      ST_DECIDE: begin
        if (count_q == '0) begin
          // empty ring: idle tick
          time_d    = time_q + CLK_W'(1);
          seed_d    = 1'b0;
          cnt_d     = '0;
          chk_vld_d = 1'b0;
          state_d   = ST_SCAN;
        end else begin
          state_d = ST_POP;
        end
      end

      ST_POP: begin
        s_d        = ring_rd;
        proc_raddr = ring_rd;
        rem_raddr  = ring_rd;
        head_d     = head_inc;
        count_d    = count_q - CNT_W'(1);
        state_d    = ST_CALC;
      end

      ST_CALC: begin
        rem_we         = 1'b1;
        started_d[s_q] = 1'b1;
        time_d         = time_q + CLK_W'(run_len);
        kind_d         = KIND_RUN;
        arr_d          = arr_rd;
        burst_d        = burst_rd;
        if (rem_cur == run_len) begin
          done_d = 1'b1;
          fin_d  = fin_q + CNT_W'(1);
        end
        state_d = ST_TAT;
      end

      ST_TAT: begin
        tat_d     = time_q - CLK_W'(arr_q);
        seed_d    = 1'b0;
        cnt_d     = '0;
        chk_vld_d = 1'b0;
        state_d   = ST_SCAN;
      end

      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          o_kind_d    = kind_q;
          o_slot_d    = (kind_q == KIND_RUN) ? SLOT_W'(s_q) : '0;
          o_start_d   = start_q;
          o_end_d     = time_q;
          o_done_d    = done_q;
          o_comp_d    = done_q ? time_q : '0;
          o_tat_d     = done_q ? tat_q : '0;
          o_wait_d    = done_q ? (tat_q - CLK_W'(burst_q)) : '0;
          o_all_d     = (fin_q >= n_use);
          // preempted process goes behind the new arrivals
          if ((kind_q == KIND_RUN) && !done_q && (count_q < CNT_W'(MAX_PROCS))) begin
            ring_we    = 1'b1;
            ring_wdata = s_q;
            count_d    = count_q + CNT_W'(1);
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tq_q        <= QUANT_W'(1);
      pc_q        <= PCNT_W'(1);
      started_q   <= '0;
      queued_q    <= '0;
      head_q      <= '0;
      count_q     <= '0;
      time_q      <= '0;
      fin_q       <= '0;
      seeded_q    <= 1'b0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      queued_q    <= queued_d;
      head_q      <= head_d;
      count_q     <= count_d;
      time_q      <= time_d;
      fin_q       <= fin_d;
      seeded_q    <= seeded_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_addr_i))
          CFG_QUANTUM: tq_q <= cfg_wdata_i[QUANT_W-1:0];
          CFG_PCOUNT:  pc_q <= cfg_wdata_i[PCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q    <= seed_d;
    cnt_q     <= cnt_d;
    chk_idx_q <= chk_idx_d;
    s_q       <= s_d;
    kind_q    <= kind_d;
    start_q   <= start_d;
    done_q    <= done_d;
    arr_q     <= arr_d;
    burst_q   <= burst_d;
    tat_q     <= tat_d;
    o_kind_q  <= o_kind_d;
    o_slot_q  <= o_slot_d;
    o_start_q <= o_start_d;
    o_end_q   <= o_end_d;
    o_done_q  <= o_done_d;
    o_comp_q  <= o_comp_d;
    o_tat_q   <= o_tat_d;
    o_wait_q  <= o_wait_d;
    o_all_q   <= o_all_d;
  end

  // --------------------------------------------------------------------------
  // outputs
  // --------------------------------------------------------------------------
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tdata  = {6'd0, o_all_q, o_wait_q, o_tat_q, o_comp_q, o_done_q,
                          o_end_q, o_start_q, o_slot_q};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `RRD_ASSERT(a_ring_bound, clk_i, rst_ni, count_q <= CNT_W'(MAX_PROCS))
  `RRD_ASSERT(a_fin_bound, clk_i, rst_ni, fin_q <= CNT_W'(MAX_PROCS))
  `RRD_ASSERT(a_load_clears, clk_i, rst_ni, (in_acc && in_op == OP_LOAD) |=> (time_q == '0 && count_q == '0 && queued_q == '0))
  `RRD_ASSERT_NEVER(a_done_not_all, clk_i, rst_ni, out_valid_q && o_kind_q == KIND_ALL_DONE && !o_all_q)

endmodule

[test/round_robin_dispatcher_tb.sv]
// ----------------------------------------------------------------------------
// round_robin_dispatcher_tb
// Self-checking bench for the round-robin dispatcher. A queue-fed driver
// streams load and dispatch beats with random gaps. A scheduler model in
// the bench predicts every slice result. A monitor compares each result
// beat field by field, while the receiver stalls at random and now and then
// holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module round_robin_dispatcher_tb;
  import rrd_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int SETTLE     = 60;      // covers a first dispatch with its seeding scan
  localparam int RAND_ITEMS = 600;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    opcode_e         op;
    logic [3:0]      slot;
    logic [11:0]     arrival;
    logic [11:0]     burst;
  } sched_item_t;

  typedef struct {
    kind_e           kind;
    logic [3:0]      slot;
    logic [CLK_W-1:0] t_start;
    logic [CLK_W-1:0] t_end;
    logic            done;
    logic [CLK_W-1:0] completed;
    logic [CLK_W-1:0] turnaround;
    logic [CLK_W-1:0] waited;
    logic            all_done;
  } slice_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  cfg_idx_e            cfg_addr_i    = CFG_QUANTUM;
  logic [CFG_W-1:0]    cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_DW-1:0]    s_axis_tdata  = '0;
  opcode_e             s_axis_tuser  = OP_LOAD;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]   m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  round_robin_dispatcher i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // slot, arrival_time, burst_time
    .s_axis_tuser  (s_axis_tuser),   // opcode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // run_slot, slice_start, slice_end, process_done, completion_time,
    // turnaround_time, waiting_time, all_complete
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)    // slice_kind
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scheduler model
  // --------------------------------------------------------------------------
  logic [11:0]      quantum_r = 12'd1;
  logic [4:0]       pcount_r  = 5'd1;
  logic [11:0]      arr_tab [MAX_PROCS];
  logic [11:0]      bur_tab [MAX_PROCS];
  logic [11:0]      rem_tab [MAX_PROCS];
  bit               queued  [MAX_PROCS];
  logic [3:0]       ring    [MAX_PROCS];
  int unsigned      ring_hd;
  int unsigned      ring_cnt;
  logic [CLK_W-1:0] now_t;
  int unsigned      finished;
  bit               seeded_f;

  slice_t           slice_q [$];
  sched_item_t      pending [$];
  int unsigned      fails = 0;
  int unsigned      slices_checked = 0;
  int unsigned      random_items = 0;

  function automatic int unsigned slots_in_use();
    if (pcount_r == 0) return 1;
    if (pcount_r > MAX_PROCS) return MAX_PROCS;
    return 32'(pcount_r);
  endfunction

  function automatic bit schedule_done();
    return finished >= slots_in_use();
  endfunction

  function automatic void ring_push(logic [3:0] s);
    if (ring_cnt >= MAX_PROCS) return;
    ring[(ring_hd + ring_cnt) % MAX_PROCS] = s;
    ring_cnt++;
  endfunction

  function automatic void admit_arrivals();
    for (int i = 0; i < slots_in_use(); i++) begin
      if ({8'd0, arr_tab[i]} <= now_t && !queued[i] && rem_tab[i] != 0) begin
        ring_push(i[3:0]);
        queued[i] = 1'b1;
      end
    end
  endfunction

  function automatic void clear_schedule();
    for (int i = 0; i < MAX_PROCS; i++) begin
      rem_tab[i] = bur_tab[i];
      queued[i]  = 1'b0;
    end
    ring_hd  = 0;
    ring_cnt = 0;
    now_t    = '0;
    finished = 0;
    seeded_f = 1'b0;
  endfunction

  // Advances the model by one accepted beat; a dispatch queues its slice.
  function automatic void schedule_step(sched_item_t it);
    int unsigned      q;
    logic [3:0]       s;
    logic [11:0]      run;
    logic [CLK_W-1:0] tat;
    slice_t           e;
    if (it.op == OP_LOAD) begin
      arr_tab[it.slot] = it.arrival;
      bur_tab[it.slot] = (it.burst == 0) ? 12'd1 : it.burst;
      clear_schedule();
      return;
    end
    e = '{kind: KIND_IDLE, default: '0};
    q = (quantum_r == 0) ? 1 : 32'(quantum_r);
    e.t_start = now_t;
    if (schedule_done()) begin
      e.kind     = KIND_ALL_DONE;
      e.t_end    = now_t;
      e.all_done = 1'b1;
    end else begin
      if (!seeded_f) begin
        admit_arrivals();
        seeded_f = 1'b1;
      end
      if (ring_cnt == 0) begin
        // nothing ready: one idle tick
        now_t   = now_t + 1'b1;
        e.t_end = now_t;
        admit_arrivals();
      end else begin
        s       = ring[ring_hd];
        ring_hd = (ring_hd + 1) % MAX_PROCS;
        ring_cnt--;
        run        = (rem_tab[s] < q) ? rem_tab[s] : q[11:0];
        rem_tab[s] = rem_tab[s] - run;
        now_t      = now_t + run;
        admit_arrivals();
        e.kind  = KIND_RUN;
        e.slot  = s;
        e.t_end = now_t;
        if (rem_tab[s] == 0) begin
          tat          = now_t - {8'd0, arr_tab[s]};
          finished++;
          e.done       = 1'b1;
          e.completed  = now_t;
          e.turnaround = tat;
          e.waited     = tat - {8'd0, bur_tab[s]};
        end else begin
          ring_push(s);  // preempted process goes behind the new arrivals
        end
        e.all_done = schedule_done();
      end
    end
    slice_q.push_back(e);
  endfunction

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  function automatic int unsigned draw_gap(ref int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 14);
  endfunction

  sched_item_t cur_item;
  bit          on_bus = 1'b0;
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        schedule_step(cur_item);
        on_bus = 1'b0;
        in_gap = draw_gap(in_calm);
      end
      if (!on_bus) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending.size() > 0) begin
          cur_item = pending.pop_front();
          on_bus   = 1'b1;
          s_axis_tdata <= {4'd0, cur_item.burst, cur_item.arrival, cur_item.slot};
          s_axis_tuser <= cur_item.op;
        end
      end
      s_axis_tvalid <= on_bus;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: per-beat stalls plus periodic long hold-offs
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 40;
  int unsigned out_stall = 0;
  int unsigned out_calm = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (slices_checked >= next_hold_at) begin
      hold_left    <= HOLD_LEN;
      next_hold_at <= next_hold_at + 300;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) out_stall = draw_gap(out_calm);
      else if (out_stall > 0) out_stall--;
      m_axis_tready <= (hold_left == 0) && (out_stall == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [CLK_W-1:0] want,
                                      logic [CLK_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  slice_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (slice_q.size() == 0) begin
        $error("result beat with no slice outstanding");
        fails++;
      end else begin
        want = slice_q.pop_front();
        check_field("slice_kind",      CLK_W'(want.kind), CLK_W'(m_axis_tuser));
        check_field("run_slot",        CLK_W'(want.slot), CLK_W'(m_axis_tdata[3:0]));
        check_field("slice_start",     want.t_start,      m_axis_tdata[23:4]);
        check_field("slice_end",       want.t_end,        m_axis_tdata[43:24]);
        check_field("process_done",    CLK_W'(want.done), CLK_W'(m_axis_tdata[44]));
        check_field("completion_time", want.completed,    m_axis_tdata[64:45]);
        check_field("turnaround_time", want.turnaround,   m_axis_tdata[84:65]);
        check_field("waiting_time",    want.waited,       m_axis_tdata[104:85]);
        check_field("all_complete",    CLK_W'(want.all_done), CLK_W'(m_axis_tdata[105]));
      end
      slices_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_item(opcode_e op, logic [3:0] slot, logic [11:0] arrival,
                           logic [11:0] burst);
    pending.push_back('{op: op, slot: slot, arrival: arrival, burst: burst});
  endtask

  task automatic drain_input();
    while (pending.size() != 0 || on_bus) @(posedge clk_i);
  endtask

  // block idle: all beats taken, all slices back, last load settled
  task automatic wait_idle();
    drain_input();
    while (slice_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_QUANTUM) quantum_r = val;
    else pcount_r = val[4:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [11:0] draw_arrival();
    if ($urandom_range(0, 9) < 8) return 12'($urandom_range(0, 15));
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [11:0] draw_burst();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) return 12'($urandom_range(0, 12));
    if (pick < 17) return 12'($urandom_range(0, 60));
    return 12'($urandom_range(0, 4095));
  endfunction

  // One schedule: load some slots, then dispatch until done or capped (or a noise mix).
  task automatic run_job();
    int unsigned n, k, sent;
    n = slots_in_use();
    if ($urandom_range(0, 6) == 0) begin
      // noise: arbitrary mix of beats
      repeat (10) begin
        push_item($urandom_range(0, 1) ? OP_DISPATCH : OP_LOAD, 4'($urandom_range(0, 15)),
                  12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        random_items++;
      end
      return;
    end
    // an empty load list keeps the old schedule under the new settings
    k = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, n);
    repeat (k) begin
      push_item(OP_LOAD, 4'($urandom_range(0, n - 1)), draw_arrival(), draw_burst());
      random_items++;
    end
    sent = 0;
    while (sent < 40) begin
      repeat (8) push_item(OP_DISPATCH, '0, '0, '0);
      sent += 8;
      random_items += 8;
      drain_input();
      if (schedule_done()) break;
    end
    repeat ($urandom_range(0, 2)) begin
      push_item(OP_DISPATCH, 4'($urandom_range(0, 15)), '0, '0);
      random_items++;
    end
  endtask

  initial begin
    int unsigned pick;
    for (int i = 0; i < MAX_PROCS; i++) begin
      arr_tab[i] = '0;
      bur_tab[i] = '0;
      ring[i]    = '0;
    end
    clear_schedule();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every slot gets loaded once; field extremes and a zero burst
    write_reg(CFG_QUANTUM, 12'd1);
    write_reg(CFG_PCOUNT, 12'd16);
    push_item(OP_LOAD, 4'd0,  12'd0,    12'd0);
    push_item(OP_LOAD, 4'd1,  12'd0,    12'd4095);
    push_item(OP_LOAD, 4'd2,  12'hAAA,  12'h555);
    push_item(OP_LOAD, 4'd3,  12'h555,  12'hAAA);
    push_item(OP_LOAD, 4'd15, 12'd4095, 12'd1);
    for (int i = 4; i < 15; i++) push_item(OP_LOAD, i[3:0], i[11:0] & 12'd3, 12'd2);
    repeat (4) push_item(OP_DISPATCH, 4'd15, 12'd4095, 12'd4095);
    wait_idle();

    // single slot, widest quantum: two idle ticks, a run, then all-done
    write_reg(CFG_QUANTUM, 12'd4095);
    write_reg(CFG_PCOUNT, 12'd1);
    push_item(OP_LOAD, 4'd0, 12'd2, 12'd1);
    repeat (5) push_item(OP_DISPATCH, '0, '0, '0);
    wait_idle();

    while (random_items < RAND_ITEMS) begin
      pick = $urandom_range(0, 3);
      case (pick)
        0: write_reg(CFG_QUANTUM, 12'd1);
        1: write_reg(CFG_QUANTUM, 12'd4095);
        2: write_reg(CFG_QUANTUM, 12'($urandom_range(1, 8)));
        default: write_reg(CFG_QUANTUM, 12'($urandom_range(1, 4095)));
      endcase
      pick = $urandom_range(0, 3);
      case (pick)
        0: write_reg(CFG_PCOUNT, 12'd1);
        1: write_reg(CFG_PCOUNT, 12'd16);
        default: write_reg(CFG_PCOUNT, 12'($urandom_range(1, 16)));
      endcase
      repeat ($urandom_range(2, 4)) run_job();
      wait_idle();
    end

    wait_idle();
    if (fails == 0) begin
      $display("round_robin_dispatcher_tb: PASS");
    end else begin
      $display("round_robin_dispatcher_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 800000);
    $display("round_robin_dispatcher_tb: FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/rrd_pkg.sv
rtl/rrd_ram.sv
rtl/round_robin_dispatcher.sv
test/round_robin_dispatcher_tb.sv
